// ===== hdl/rosi_pkg.sv =====
`default_nettype none

package rosi_pkg;

    // fixed field widths of the streams and the register port
    localparam int FIELD_W   = 32;
    localparam int EXT_W     = 31;
    localparam int DIST_W    = 31;
    localparam int CFG_W     = 17;
    localparam int S_TDATA_W = 320;
    localparam int M_TDATA_W = 32;

    // one full product of two fields, and the sum of three shifted products
    localparam int PROD_W = 2 * FIELD_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [DIST_W-1:0] OUT_MAX = {DIST_W{1'b1}};

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_PARALLEL_THR = 1'b0,
        CFG_MIN_HIT      = 1'b1
    } cfg_index_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic first;
    } mac_ctl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rosi_mac.sv =====
`default_nettype none

module rosi_mac
    import rosi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mac_ctl_t                      ctl,
    input  wire logic signed [FIELD_W-1:0]     op_a,
    input  wire logic signed [FIELD_W-1:0]     op_b,
    output logic signed [DATA_WIDTH-1:0]       acc_sat
);

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pvalid_reg;
    logic                     pfirst_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  prod_ext;

    // floor shift of the exact product
    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign prod_ext = ACC_W'(prod_sh);

    // control flags of the product stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            pfirst_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctl.issue;
            pfirst_reg <= ctl.first;
        end
    end

    // product register, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (pvalid_reg)
        begin
            acc_reg <= pfirst_reg ? prod_ext : acc_reg + prod_ext;
        end
    end

    // saturate the running sum to the data range
    always_comb
    begin
        if (acc_reg > ACC_W'(DMAX))
        begin
            acc_sat = DMAX;
        end
        else if (acc_reg < ACC_W'(DMIN))
        begin
            acc_sat = DMIN;
        end
        else
        begin
            acc_sat = acc_reg[DATA_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rosi_div.sv =====
`default_nettype none

module rosi_div
    import rosi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [((DATA_WIDTH-1 > EXT_W) ? DATA_WIDTH-1 : EXT_W)+1:0] num,
    input  wire logic signed [DATA_WIDTH-1:0]          den,
    output div_stat_t                                  stat,
    output logic signed [DATA_WIDTH-1:0]               quot
);

    // magnitude bits of the numerator and bits shifted through the divider
    localparam int NUM_W  = ((DATA_WIDTH-1 > EXT_W) ? DATA_WIDTH-1 : EXT_W) + 1;
    localparam int DIVD_W = NUM_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic [DIVD_W-1:0]       dvd_reg;
    logic [DATA_WIDTH-1:0]   dmag_reg;
    logic [DATA_WIDTH-1:0]   rem_reg;
    logic [DATA_WIDTH-2:0]   q_reg;
    logic                    ovf_reg;

    logic [NUM_W:0]          num_neg;
    logic [NUM_W-1:0]        nmag;
    logic [DATA_WIDTH-1:0]   dmag;
    logic [DATA_WIDTH:0]     rem2;
    logic [DATA_WIDTH:0]     rem_sub;
    logic                    ge;
    logic [DATA_WIDTH-1:0]   q_ext;

    // operand magnitudes
    assign num_neg = (NUM_W+1)'(0) - num;
    assign nmag    = num[NUM_W] ? num_neg[NUM_W-1:0] : num[NUM_W-1:0];
    assign dmag    = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : DATA_WIDTH'(den);

    // one restoring step: bring down the next dividend bit
    assign rem2    = {rem_reg, dvd_reg[DIVD_W-1]};
    assign ge      = rem2 >= {1'b0, dmag_reg};
    assign rem_sub = ge ? (rem2 - {1'b0, dmag_reg}) : rem2;

    // signed, saturated quotient
    assign q_ext = {1'b0, q_reg};
    always_comb
    begin
        if (ovf_reg)
        begin
            quot = neg_reg ? DMIN : DMAX;
        end
        else
        begin
            quot = neg_reg ? -$signed(q_ext) : $signed(q_ext);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // step counter and handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath of the shift-subtract loop
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= num[NUM_W] ^ den[DATA_WIDTH-1];
            dvd_reg  <= {nmag, {FRAC_BITS{1'b0}}};
            dmag_reg <= dmag;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_sub[DATA_WIDTH-1:0];
            q_reg   <= {q_reg[DATA_WIDTH-3:0], ge};
            ovf_reg <= ovf_reg | q_reg[DATA_WIDTH-2];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ray_obb_slab_intersection.sv =====
// a parallel slab skips the divisions, a slab after a miss skips all work; one item at a time
// the shared radix-2 divider, one quotient bit per cycle, sets the slab time
// the result goes to an output register after the last slab finishes, once that register is free
// rst_n clears the interval, the miss flag and the stream flags, and resets both registers
`default_nettype none

module ray_obb_slab_intersection
    import rosi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // ray_dir_x, ray_dir_y, ray_dir_z, rel_origin_x, rel_origin_y, rel_origin_z,
    // axis_x, axis_y, axis_z, half_extent, one zero pad bit
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // entry_distance, one zero pad bit
    output logic [M_TDATA_W-1:0]       m_tdata,
    // hit
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int NUM_W = ((DATA_WIDTH-1 > EXT_W) ? DATA_WIDTH-1 : EXT_W) + 1;
    localparam int CMP_W = ((DATA_WIDTH > CFG_W) ? DATA_WIDTH : CFG_W) + 1;
    localparam int OCM_W = (DATA_WIDTH > EXT_W) ? DATA_WIDTH : EXT_W;
    localparam int EW    = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_DRAIN,
        S_CHK,
        S_DIV1,
        S_DIV2,
        S_UPD,
        S_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [2:0]                    cnt_reg, cnt_next;
    logic signed [FIELD_W-1:0]     opa_reg [6];
    logic signed [FIELD_W-1:0]     opa_next [6];
    logic signed [FIELD_W-1:0]     opb_reg [6];
    logic signed [FIELD_W-1:0]     opb_next [6];
    logic [EXT_W-1:0]              ext_reg, ext_next;
    logic                          last_reg, last_next;
    logic signed [DATA_WIDTH-1:0]  dd_reg, dd_next;
    logic signed [DATA_WIDTH-1:0]  od_reg, od_next;
    logic signed [DATA_WIDTH-1:0]  t1_reg, t1_next;
    logic signed [DATA_WIDTH-1:0]  t2_reg, t2_next;
    logic signed [DATA_WIDTH-1:0]  enter_reg, enter_next;
    logic signed [DATA_WIDTH-1:0]  exit_reg, exit_next;
    logic                          missed_reg, missed_next;
    logic [CFG_W-1:0]              thr_reg, thr_next;
    logic [CFG_W-1:0]              min_hit_reg, min_hit_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          m_tuser_reg, m_tuser_next;
    logic [DIST_W-1:0]             dist_reg, dist_next;

    mac_ctl_t                      mac_ctl;
    logic signed [DATA_WIDTH-1:0]  acc_sat;
    logic                          div_start;
    logic signed [NUM_W:0]         div_num;
    div_stat_t                     div_stat;
    logic signed [DATA_WIDTH-1:0]  quot;

    logic [DATA_WIDTH-1:0]         dd_mag;
    logic [DATA_WIDTH-1:0]         od_mag;
    logic                          parallel;
    logic                          outside;
    logic signed [NUM_W:0]         ext_s;
    logic signed [NUM_W:0]         num1;
    logic signed [NUM_W:0]         num2;
    logic signed [DATA_WIDTH-1:0]  lo;
    logic signed [DATA_WIDTH-1:0]  hi;
    logic signed [DATA_WIDTH-1:0]  enter_new;
    logic signed [DATA_WIDTH-1:0]  exit_new;
    logic signed [CMP_W-1:0]       enter_h;
    logic signed [CMP_W-1:0]       min_h;
    logic signed [EW-1:0]          enter_e;
    logic                          hit;
    logic [DIST_W-1:0]             dist_sat;
    logic                          s_xfer;
    logic                          out_free;

    rosi_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .op_a    (opa_reg[0]),
        .op_b    (opb_reg[0]),
        .acc_sat (acc_sat)
    );

    rosi_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dd_reg),
        .stat  (div_stat),
        .quot  (quot)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {1'b0, dist_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // products issued one per cycle from the heads of the operand lines
    assign mac_ctl.issue = (state_reg == S_DOT);
    assign mac_ctl.first = (cnt_reg == 3'd0) || (cnt_reg == 3'd3);

    // parallel slab test on the direction dot, outside test on the origin dot
    assign dd_mag   = dd_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-dd_reg) : DATA_WIDTH'(dd_reg);
    assign od_mag   = acc_sat[DATA_WIDTH-1] ? DATA_WIDTH'(-acc_sat) : DATA_WIDTH'(acc_sat);
    assign parallel = (dd_reg == '0) || (CMP_W'(dd_mag) < CMP_W'(thr_reg));
    assign outside  = OCM_W'(od_mag) > OCM_W'(ext_reg);

    // slab numerators
    assign ext_s   = $signed((NUM_W+1)'(ext_reg));
    assign num1    = ext_s - (NUM_W+1)'(acc_sat);
    assign num2    = -ext_s - (NUM_W+1)'(od_reg);
    assign div_num = (state_reg == S_CHK) ? num1 : num2;
    assign div_start = ((state_reg == S_CHK) && !parallel) ||
                       ((state_reg == S_DIV1) && div_stat.done);

    // interval narrowing
    assign lo        = (t1_reg > t2_reg) ? t2_reg : t1_reg;
    assign hi        = (t1_reg > t2_reg) ? t1_reg : t2_reg;
    assign enter_new = (lo > enter_reg) ? lo : enter_reg;
    assign exit_new  = (hi < exit_reg) ? hi : exit_reg;

    // result fields
    assign enter_h  = CMP_W'(enter_reg);
    assign min_h    = $signed(CMP_W'(min_hit_reg));
    assign enter_e  = EW'(enter_reg);
    assign hit      = !missed_reg && (enter_h > min_h);
    assign dist_sat = (enter_e > $signed(EW'(OUT_MAX))) ? OUT_MAX : enter_e[DIST_W-1:0];

    // sequencer and next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        ext_next      = ext_reg;
        last_next     = last_reg;
        dd_next       = dd_reg;
        od_next       = od_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        enter_next    = enter_reg;
        exit_next     = exit_reg;
        missed_next   = missed_reg;
        thr_next      = thr_reg;
        min_hit_next  = min_hit_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        dist_next     = dist_reg;

        // register writes
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_PARALLEL_THR: thr_next     = cfg_data;
                CFG_MIN_HIT:      min_hit_next = cfg_data;
                default:          ;
            endcase
        end

        // output register drains on a transfer
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    opa_next[0] = s_tdata[0*FIELD_W +: FIELD_W];
                    opa_next[1] = s_tdata[1*FIELD_W +: FIELD_W];
                    opa_next[2] = s_tdata[2*FIELD_W +: FIELD_W];
                    opa_next[3] = s_tdata[3*FIELD_W +: FIELD_W];
                    opa_next[4] = s_tdata[4*FIELD_W +: FIELD_W];
                    opa_next[5] = s_tdata[5*FIELD_W +: FIELD_W];
                    opb_next[0] = s_tdata[6*FIELD_W +: FIELD_W];
                    opb_next[1] = s_tdata[7*FIELD_W +: FIELD_W];
                    opb_next[2] = s_tdata[8*FIELD_W +: FIELD_W];
                    opb_next[3] = s_tdata[6*FIELD_W +: FIELD_W];
                    opb_next[4] = s_tdata[7*FIELD_W +: FIELD_W];
                    opb_next[5] = s_tdata[8*FIELD_W +: FIELD_W];
                    ext_next    = s_tdata[9*FIELD_W +: EXT_W];
                    last_next   = s_tlast;
                    cnt_next    = 3'd0;
                    state_next  = missed_reg ? S_FIN : S_DOT;
                end
            end

            S_DOT:
            begin
                // shift both operand lines toward the multiplier
                for (int k = 0; k < 5; k++)
                begin
                    opa_next[k] = opa_reg[k+1];
                    opb_next[k] = opb_reg[k+1];
                end
                // direction dot is complete once its third product has passed the product register and the accumulator
                if (cnt_reg == 3'd4)
                begin
                    dd_next = acc_sat;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_CHK;
            end

            S_CHK:
            begin
                od_next = acc_sat;
                if (parallel)
                begin
                    if (outside)
                    begin
                        missed_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV1;
                end
            end

            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    t1_next    = quot;
                    state_next = S_DIV2;
                end
            end

            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    t2_next    = quot;
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                enter_next = enter_new;
                exit_next  = exit_new;
                if (enter_new > exit_new)
                begin
                    missed_next = 1'b1;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit;
                    dist_next     = hit ? dist_sat : '0;
                    enter_next    = '0;
                    exit_next     = DMAX;
                    missed_next   = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            for (int k = 0; k < 6; k++)
            begin
                opa_reg[k] <= '0;
                opb_reg[k] <= '0;
            end
            ext_reg      <= '0;
            last_reg     <= 1'b0;
            dd_reg       <= '0;
            od_reg       <= '0;
            t1_reg       <= '0;
            t2_reg       <= '0;
            enter_reg    <= '0;
            exit_reg     <= DMAX;
            missed_reg   <= 1'b0;
            thr_reg      <= CFG_W'(1);
            min_hit_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
            dist_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            opa_reg      <= opa_next;
            opb_reg      <= opb_next;
            ext_reg      <= ext_next;
            last_reg     <= last_next;
            dd_reg       <= dd_next;
            od_reg       <= od_next;
            t1_reg       <= t1_next;
            t2_reg       <= t2_next;
            enter_reg    <= enter_next;
            exit_reg     <= exit_next;
            missed_reg   <= missed_next;
            thr_reg      <= thr_next;
            min_hit_reg  <= min_hit_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tuser_reg  <= m_tuser_next;
            dist_reg     <= dist_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rosi_chk.sv =====
`default_nettype none

module rosi_chk
    import rosi_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser
);

    // a slab transfer always starts work that holds off the next one
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a miss carries a zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero distance");

    // pad bit stays clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[M_TDATA_W-1])
        else $error("pad bit of result set");

    // a new result is loaded only while a slab is being finished
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind ray_obb_slab_intersection rosi_chk u_rosi_chk (.*);

`default_nettype wire
